// ===== hdl/sfc_pkg.sv =====
// package: types, constants and fixed-point helpers for the speech frame filter chain
`default_nettype none
package sfc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int SUM_BITS    = 31;
   localparam int DIFF_BITS   = 26;
   localparam int HP_BITS     = 42;
   localparam int H_BITS      = 27;
   localparam int EMPH_BITS   = 28;
   localparam int LP_BITS     = 45;
   localparam int OUT_BITS    = 32;
   localparam int COEFF_BITS  = 15;
   localparam int Q_FRAC      = 15;
   localparam int MULA_BITS   = 17;
   localparam int MULB_BITS   = 48;
   localparam int PROD_BITS   = 64;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [MULA_BITS-1:0] Q_ONE = MULA_BITS'(32768);

   localparam logic [COEFF_BITS-1:0] HIGHPASS_RESET = COEFF_BITS'(31769);
   localparam logic [COEFF_BITS-1:0] LOWPASS_RESET  = COEFF_BITS'(20022);
   localparam logic [COEFF_BITS-1:0] EMPHASIS_RESET = COEFF_BITS'(31785);

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_HIGHPASS = 2'd0;
   localparam csr_index_type CSR_LOWPASS  = 2'd1;
   localparam csr_index_type CSR_EMPHASIS = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          frame_end;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] sample_out;
      logic                       last_out;
      logic                       frame_forced;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_DIFF,
      ST_TERM,
      ST_HP,
      ST_EMPH,
      ST_ETERM,
      ST_LP1,
      ST_LP2,
      ST_SUM,
      ST_EMIT
   } state_type;

   // divide by 2^15, truncating toward zero
   function automatic logic signed [PROD_BITS-1:0] trunc_q15(
      input logic signed [PROD_BITS-1:0] v);
      logic signed [PROD_BITS-1:0] adj;
      logic signed [PROD_BITS-1:0] b;
      adj = v[PROD_BITS-1] ? 64'sd32767 : 64'sd0;
      b = v + adj;
      return b >>> Q_FRAC;
   endfunction

   // saturate to a signed width
   function automatic logic signed [PROD_BITS-1:0] sat_q(
      input logic signed [PROD_BITS-1:0] v, input int bits);
      logic signed [PROD_BITS-1:0] hi;
      logic signed [PROD_BITS-1:0] lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sfc_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module sfc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hdl/speech_frame_filter_chain.sv =====
// top level: frame collect, mean removal and high-pass, pre-emphasis, low-pass chain
// requests are taken only while not busy; at the frame's last request the mean
// divider runs (one quotient bit a cycle), then a ram read state, then each sample
// steps in turn through the diff, term, high-pass, emphasis, emphasis term, low-pass
// product, sum and emit states, sharing the 17x48 multiplier.
// busy is high from the frame's last request until its last result; synchronous reset
// clears the frame, filter memories and restores default coefficients.
`default_nettype none
module speech_frame_filter_chain
   import sfc_pkg::*;
#(
   parameter int FRAME_MAX = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_payload,
   output logic                          rsp_strobe,
   output rsp_type                       rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire csr_index_type            csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
   localparam int CW = $clog2(FRAME_MAX + 1);
   localparam logic [4:0] DIV_LAST = 5'(SUM_BITS - 1);

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic forced_ff, forced_in;
   logic [SUM_BITS-1:0] mag_ff, mag_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic neg_ff, neg_in;
   logic signed [SUM_BITS-1:0] mean_ff, mean_in;

   logic signed [DIFF_BITS-1:0] d_last_ff, d_last_in;
   logic signed [HP_BITS-1:0] y_last_ff, y_last_in;
   logic signed [EMPH_BITS-1:0] p_ff, p_in;
   logic signed [LP_BITS-1:0] l_last_ff, l_last_in;
   logic signed [H_BITS-1:0] h_ff, h_in;
   logic signed [DIFF_BITS-1:0] d_ff, d_in;
   logic signed [MULB_BITS-1:0] t_ff, t_in;
   logic signed [MULB_BITS-1:0] e_ff, e_in;
   logic signed [PROD_BITS-1:0] acc_ff, acc_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;

   logic [COEFF_BITS-1:0] hp_coeff_ff, hp_coeff_in;
   logic [COEFF_BITS-1:0] lp_coeff_ff, lp_coeff_in;
   logic [COEFF_BITS-1:0] emph_coeff_ff, emph_coeff_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [MULA_BITS-1:0] mula;
   logic signed [MULB_BITS-1:0] mulb;
   logic signed [MULA_BITS+MULB_BITS-1:0] mul_full;

   logic ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [AW-1:0] ram_rd_addr;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic accept;

   sfc_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(FRAME_MAX),
      .AW   (AW)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_payload.sample_in),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign csr_ready   = 1'b1;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
   assign ram_wr_en   = accept;
   assign ram_wr_addr = count_ff[AW-1:0];
   assign mul_full    = mula * mulb;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         sum_ff        <= '0;
         d_last_ff     <= '0;
         y_last_ff     <= '0;
         p_ff          <= '0;
         l_last_ff     <= '0;
         hp_coeff_ff   <= HIGHPASS_RESET;
         lp_coeff_ff   <= LOWPASS_RESET;
         emph_coeff_ff <= EMPHASIS_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         d_last_ff     <= d_last_in;
         y_last_ff     <= y_last_in;
         p_ff          <= p_in;
         l_last_ff     <= l_last_in;
         hp_coeff_ff   <= hp_coeff_in;
         lp_coeff_ff   <= lp_coeff_in;
         emph_coeff_ff <= emph_coeff_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      n_ff       <= n_in;
      idx_ff     <= idx_in;
      forced_ff  <= forced_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      neg_ff     <= neg_in;
      mean_ff    <= mean_in;
      h_ff       <= h_in;
      d_ff       <= d_in;
      t_ff       <= t_in;
      e_ff       <= e_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

   // configuration writes
   always_comb begin
      hp_coeff_in   = hp_coeff_ff;
      lp_coeff_in   = lp_coeff_ff;
      emph_coeff_in = emph_coeff_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HIGHPASS: hp_coeff_in   = csr_data[COEFF_BITS-1:0];
            CSR_LOWPASS:  lp_coeff_in   = csr_data[COEFF_BITS-1:0];
            CSR_EMPHASIS: emph_coeff_in = csr_data[COEFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and shared multiplier operand select
   always_comb begin
      logic signed [SUM_BITS-1:0] x_sum;
      logic signed [SUM_BITS-1:0] sum_new;
      logic [CW-1:0] cnt_new;
      logic [CW:0] rem_sh;
      logic qbit;
      logic signed [OUT_BITS-1:0] x_ext;
      logic signed [PROD_BITS-1:0] diff;
      logic signed [DIFF_BITS-1:0] d;
      logic signed [MULB_BITS-1:0] t;
      logic signed [HP_BITS-1:0] y;
      logic signed [MULB_BITS-1:0] e;
      logic signed [PROD_BITS-1:0] sumw;
      logic last;

      x_sum   = SUM_BITS'(req_payload.sample_in);
      sum_new = sum_ff + x_sum;
      cnt_new = count_ff + CW'(1);
      rem_sh  = {rem_ff, mag_ff[SUM_BITS-1]};
      qbit    = (rem_sh >= {1'b0, n_ff});
      x_ext   = OUT_BITS'($signed(ram_rd_data));
      diff    = PROD_BITS'(x_ext) - PROD_BITS'(mean_ff);
      d       = DIFF_BITS'(sat_q(diff, DIFF_BITS));
      t       = MULB_BITS'(y_last_ff)
                + ((MULB_BITS'(d_ff) - MULB_BITS'(d_last_ff)) <<< Q_FRAC);
      y       = HP_BITS'(sat_q(trunc_q15(prod_ff), HP_BITS));
      e       = MULB_BITS'(h_ff) - MULB_BITS'(trunc_q15(prod_ff));
      sumw    = (acc_ff <<< Q_FRAC) + prod_ff;
      last    = ((idx_ff + CW'(1)) == n_ff);

      state_in      = state_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      forced_in     = forced_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      neg_in        = neg_ff;
      mean_in       = mean_ff;
      d_last_in     = d_last_ff;
      y_last_in     = y_last_ff;
      p_in          = p_ff;
      l_last_in     = l_last_ff;
      h_in          = h_ff;
      d_in          = d_ff;
      t_in          = t_ff;
      e_in          = e_ff;
      acc_in        = acc_ff;
      prod_in       = mul_full[PROD_BITS-1:0];
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_rd_addr   = idx_ff[AW-1:0];
      mula          = '0;
      mulb          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.frame_end || cnt_new == CW'(FRAME_MAX)) begin
                  n_in       = cnt_new;
                  forced_in  = !req_payload.frame_end;
                  count_in   = '0;
                  sum_in     = '0;
                  neg_in     = sum_new[SUM_BITS-1];
                  mag_in     = sum_new[SUM_BITS-1] ? (~sum_new + SUM_BITS'(1)) : sum_new;
                  rem_in     = '0;
                  div_cnt_in = DIV_LAST;
                  idx_in     = '0;
                  state_in   = ST_DIV;
               end else begin
                  count_in = cnt_new;
                  sum_in   = sum_new;
               end
            end
         end
         ST_DIV: begin
            rem_in = qbit ? CW'(rem_sh - {1'b0, n_ff}) : rem_sh[CW-1:0];
            mag_in = {mag_ff[SUM_BITS-2:0], qbit};
            div_cnt_in = div_cnt_ff - 5'd1;
            if (div_cnt_ff == 5'd0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mean_in  = neg_ff ? (~mag_ff + SUM_BITS'(1)) : mag_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            d_in     = d;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            d_last_in = d_ff;
            t_in      = t;
            state_in  = ST_HP;
         end
         ST_HP: begin
            mula      = {2'b00, hp_coeff_ff};
            mulb      = t_ff;
            state_in  = ST_EMPH;
         end
         ST_EMPH: begin
            y_last_in = y;
            h_in      = H_BITS'(trunc_q15(PROD_BITS'(y)));
            mula      = {2'b00, emph_coeff_ff};
            mulb      = MULB_BITS'(p_ff);
            state_in  = ST_ETERM;
         end
         ST_ETERM: begin
            p_in     = EMPH_BITS'(h_ff);
            e_in     = e;
            state_in = ST_LP1;
         end
         ST_LP1: begin
            mula     = {2'b00, lp_coeff_ff};
            mulb     = e_ff;
            state_in = ST_LP2;
         end
         ST_LP2: begin
            acc_in   = prod_ff;
            mula     = Q_ONE - {2'b00, lp_coeff_ff};
            mulb     = MULB_BITS'(l_last_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            l_last_in = LP_BITS'(sat_q(trunc_q15(sumw), LP_BITS));
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.sample_out   =
               OUT_BITS'(sat_q(trunc_q15(PROD_BITS'(l_last_ff)), OUT_BITS));
            rsp_in.last_out     = last;
            rsp_in.frame_forced = forced_ff;
            idx_in              = idx_ff + CW'(1);
            ram_rd_addr         = idx_in[AW-1:0];
            state_in            = last ? ST_IDLE : ST_DIFF;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== dv/tb_speech_frame_filter_chain.sv =====
// testbench for the speech frame filter chain: random frames, coefficient sweeps, scoreboard
module tb_speech_frame_filter_chain;
   import sfc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LEN = 64;
   localparam longint Q_SCALE = 64'sd32768;
   localparam csr_index_type CSR_UNUSED = 2'd3;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = 24'sh800000;
   localparam logic [COEFF_BITS-1:0] COEFF_MAX = 15'h7FFF;

   typedef enum int {MIX_FULL, MIX_SMALL, MIX_RAIL, MIX_OFFSET} sample_mix_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_HIGHPASS;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   speech_frame_filter_chain #(.FRAME_MAX(FRAME_LEN)) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   req_type pending_req[$];
   rsp_type expected_out[$];
   bit failed = 1'b0;
   bit req_taken = 1'b0;
   bit quiet = 1'b0;
   int gap_left = 0;

   // predictor state
   longint held_samples[FRAME_LEN];
   int held_count;
   longint held_total;
   longint hp_prev_in;
   longint hp_prev_out;
   longint emph_prev;
   longint lp_prev_out;
   logic [COEFF_BITS-1:0] hp_coeff;
   logic [COEFF_BITS-1:0] lp_coeff;
   logic [COEFF_BITS-1:0] emph_coeff;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic void clear_predictor();
      held_count = 0;
      held_total = 0;
      hp_prev_in = 0;
      hp_prev_out = 0;
      emph_prev = 0;
      lp_prev_out = 0;
      hp_coeff = HIGHPASS_RESET;
      lp_coeff = LOWPASS_RESET;
      emph_coeff = EMPHASIS_RESET;
   endfunction

   // high-pass, pre-emphasis, low-pass on one mean-removed sample
   function automatic longint run_filters(input longint diff);
      longint d;
      longint t;
      longint y;
      longint h;
      longint e;
      longint l;
      d = clamp(diff, DIFF_BITS);
      t = hp_prev_out + (d - hp_prev_in) * Q_SCALE;
      y = clamp((longint'(hp_coeff) * t) / Q_SCALE, HP_BITS);
      hp_prev_in = d;
      hp_prev_out = y;
      h = y / Q_SCALE;
      e = h - (longint'(emph_coeff) * emph_prev) / Q_SCALE;
      emph_prev = clamp(h, EMPH_BITS);
      l = (longint'(lp_coeff) * (e * Q_SCALE)
           + (Q_SCALE - longint'(lp_coeff)) * lp_prev_out) / Q_SCALE;
      lp_prev_out = clamp(l, LP_BITS);
      return clamp(lp_prev_out / Q_SCALE, OUT_BITS);
   endfunction

   function automatic void predict_request(input req_type item);
      longint mean;
      bit forced;
      rsp_type want;
      if (held_count >= FRAME_LEN) begin
         held_count = 0;
         held_total = 0;
      end
      held_samples[held_count] = longint'($signed(item.sample_in));
      held_total += held_samples[held_count];
      held_count++;
      forced = !item.frame_end && held_count >= FRAME_LEN;
      if (item.frame_end || forced) begin
         mean = held_total / longint'(held_count);
         for (int i = 0; i < held_count; i++) begin
            want.sample_out = OUT_BITS'(run_filters(held_samples[i] - mean));
            want.last_out = (i == held_count - 1);
            want.frame_forced = forced;
            expected_out.push_back(want);
         end
         held_count = 0;
         held_total = 0;
      end
   endfunction

   // monitor: requests, register writes and results at the rising edge
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         clear_predictor();
         req_taken = 1'b0;
      end else begin
         req_taken = start && !busy;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HIGHPASS: hp_coeff = csr_data[COEFF_BITS-1:0];
               CSR_LOWPASS: lp_coeff = csr_data[COEFF_BITS-1:0];
               CSR_EMPHASIS: emph_coeff = csr_data[COEFF_BITS-1:0];
               default: ;
            endcase
         end
         if (req_taken) begin
            predict_request(req_payload);
         end
         if (rsp_strobe) begin
            got = rsp_payload;
            if (expected_out.size() == 0) begin
               $error("result with nothing expected: sample_out %0d", got.sample_out);
               failed = 1'b1;
            end else begin
               want = expected_out.pop_front();
               if (got.sample_out !== want.sample_out) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                     want.sample_out, got.sample_out);
                  failed = 1'b1;
               end
               if (got.last_out !== want.last_out) begin
                  $error("last_out mismatch: expected %0d, actual %0d",
                     want.last_out, got.last_out);
                  failed = 1'b1;
               end
               if (got.frame_forced !== want.frame_forced) begin
                  $error("frame_forced mismatch: expected %0d, actual %0d",
                     want.frame_forced, got.frame_forced);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // driver: presents queued requests at the falling edge, with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !req_taken) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (pending_req.size() > 0) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 7);
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_payload <= pending_req.pop_front();
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic queue_item(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
      req_type item;
      item.sample_in = value;
      item.frame_end = last;
      pending_req.push_back(item);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(
      input sample_mix_type mix, input int offset);
      case (mix)
         MIX_SMALL: return SAMPLE_BITS'(int'($urandom_range(0, 400)) - 200);
         MIX_RAIL: return $urandom_range(0, 1) ? SAMPLE_HI : SAMPLE_LO;
         MIX_OFFSET: return SAMPLE_BITS'(offset + int'($urandom_range(0, 64)) - 32);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   task automatic queue_frame(input int len, input bit marked, input sample_mix_type mix,
      input int offset);
      for (int i = 0; i < len; i++) begin
         queue_item(draw_sample(mix, offset), marked && (i == len - 1));
      end
   endtask

   task automatic queue_random_frames(input int item_goal);
      int queued;
      int len;
      int pick;
      bit marked;
      queued = 0;
      while (queued < item_goal) begin
         pick = $urandom_range(0, 19);
         marked = 1'b1;
         if (pick < 2) begin
            len = FRAME_LEN;
            marked = 1'b0;
         end else if (pick == 2) begin
            len = FRAME_LEN;
         end else if (pick == 3) begin
            len = $urandom_range(FRAME_LEN - 8, FRAME_LEN - 1);
         end else begin
            len = $urandom_range(1, 12);
         end
         queue_frame(len, marked, sample_mix_type'($urandom_range(0, 3)),
            int'($urandom_range(0, 8000000)) - 4000000);
         queued += len;
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [COEFF_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= {17'($urandom()), value};
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_coeffs(input logic [COEFF_BITS-1:0] hp, input logic [COEFF_BITS-1:0] lp,
      input logic [COEFF_BITS-1:0] emph);
      write_csr(CSR_HIGHPASS, hp);
      write_csr(CSR_LOWPASS, lp);
      write_csr(CSR_EMPHASIS, emph);
   endtask

   // all requests taken, all results in, then let the block settle
   task automatic wait_idle();
      do @(negedge clock); while (pending_req.size() != 0 || start || expected_out.size() != 0);
      repeat (60) @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default coefficients: rails, zero, odd means, alternating bits
      queue_item(SAMPLE_HI, 1'b1);
      queue_item(SAMPLE_LO, 1'b1);
      queue_item('0, 1'b1);
      queue_item(SAMPLE_HI, 1'b0);
      queue_item(SAMPLE_LO, 1'b1);
      queue_item(-24'sd1, 1'b0);
      queue_item(24'sd1, 1'b0);
      queue_item(SAMPLE_HI, 1'b0);
      queue_item(SAMPLE_HI, 1'b1);
      queue_item(24'sh555555, 1'b0);
      queue_item(24'shAAAAAA, 1'b0);
      queue_item(SAMPLE_LO, 1'b0);
      queue_item(-24'sd3, 1'b1);
      wait_idle();

      write_csr(CSR_UNUSED, 15'($urandom()));
      set_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX);
      queue_random_frames(90);
      wait_idle();

      set_coeffs('0, '0, '0);
      queue_random_frames(60);
      wait_idle();

      set_coeffs(15'($urandom()), 15'($urandom()), 15'($urandom()));
      write_csr(CSR_UNUSED, 15'($urandom()));
      queue_random_frames(100);
      wait_idle();

      set_coeffs(COEFF_MAX, 15'd1, '0);
      queue_random_frames(90);
      wait_idle();

      quiet = 1'b1;
      set_coeffs(15'($urandom()), 15'($urandom()), 15'($urandom()));
      queue_random_frames(100);
      wait_idle();

      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== speech_frame_filter_chain.f =====
hdl/sfc_pkg.sv
hdl/sfc_ram.sv
hdl/speech_frame_filter_chain.sv
dv/tb_speech_frame_filter_chain.sv
